@@ rtl/core/ipdrc_pkg.sv @@
// Package for the inter-packet delay rate control block.
// Holds field widths, arithmetic widths, request and status codes, register indexes.
// No dependencies; every other file of the block imports it.
package ipdrc_pkg;

  // Fixed constants of the rate control law.
  localparam int DELAY_CEILING = 10000;
  localparam int RATE_SCALE    = 100000;

  // Field widths.
  localparam int ACT_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int RATE_W     = 17;
  localparam int FAC_W      = 16;
  localparam int TGT_W      = 20;
  localparam int BLK_W      = 32;
  localparam int DELAY_W    = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Arithmetic widths of the slowdown and speedup paths.
  localparam int CEIL_W  = $clog2(DELAY_CEILING + 1);
  localparam int DEN_W   = 33;   // slow denominator times span
  localparam int PROD_W  = 34;   // signed factor difference times rate excess
  localparam int NUM_W   = 35;   // signed numerator
  localparam int MUL_A_W = NUM_W;
  localparam int MUL_B_W = DELAY_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DVD_W   = 56;   // delay times numerator
  localparam int CNT_W   = $clog2(DVD_W);

  // Request types.
  typedef enum logic [ACT_W-1:0] {
    ACT_REPORT  = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_START   = 2'd2,
    ACT_OTHER   = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_BLOCK = 2'd1,
    STAT_UNKNOWN   = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_NUM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_NUM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 3'd6;

endpackage

@@ rtl/core/ipdrc_in_if.sv @@
// Request channel of the inter-packet delay rate control block.
// Carries valid, ready and the request fields; depends on ipdrc_pkg.
interface ipdrc_in_if;
  import ipdrc_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic [RATE_W-1:0]   reported_error_rate;
  logic [BLK_W-1:0]    restart_block;

  modport source (output valid, output action, output reported_error_rate,
                  output restart_block, input ready);
  modport sink   (input valid, input action, input reported_error_rate,
                  input restart_block, output ready);
endinterface

@@ rtl/core/ipdrc_out_if.sv @@
// Result channel of the inter-packet delay rate control block.
// Carries valid, ready and the result fields; depends on ipdrc_pkg.
interface ipdrc_out_if;
  import ipdrc_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [DELAY_W-1:0] delay_now;
  logic [BLK_W-1:0]   block_position;

  modport source (output valid, output status, output delay_now,
                  output block_position, input ready);
  modport sink   (input valid, input status, input delay_now,
                  input block_position, output ready);
endinterface

@@ rtl/core/ipdrc_unit.sv @@
// Shared arithmetic unit: one signed multiplier and one restoring division step.
// Purely combinational; the sequencer in the top level registers every result.
// Depends on ipdrc_pkg.
module ipdrc_unit (
  input  logic signed [ipdrc_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [ipdrc_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [ipdrc_pkg::MUL_P_W-1:0] mul_p,
  input  logic        [ipdrc_pkg::DEN_W-1:0]   div_den,
  input  logic        [ipdrc_pkg::DEN_W-1:0]   div_rem,
  input  logic                                 div_in_bit,
  output logic        [ipdrc_pkg::DEN_W-1:0]   div_rem_nxt,
  output logic                                 div_qbit
);
  import ipdrc_pkg::*;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_diff;

  // Signed product; both operands are sign-extended to the product width.
  assign mul_p = mul_a * mul_b;

  // One quotient bit: shift in the next dividend bit and try to subtract.
  assign rem_sh      = {div_rem, div_in_bit};
  assign rem_diff    = rem_sh - {1'b0, div_den};
  assign div_qbit    = (rem_sh >= {1'b0, div_den});
  assign div_rem_nxt = div_qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

endmodule

@@ rtl/core/interpacket_delay_rate_control.sv @@
// Inter-packet delay rate control: keeps a sender's delay and block position.
// Restart, start and unknown requests go straight to the result step; a report takes
// up to three multiplier passes, then 56 restoring division steps, which are skipped
// when the factor is not positive. A new request is taken only after the last result
// is handed on; a waiting result stalls only the last step.
// Synchronous active-low reset clears kept state and sequencer and sets config defaults.
module interpacket_delay_rate_control (
  input  logic                                clk,
  input  logic                                rst_n,
  ipdrc_in_if.sink                            in_ch,
  ipdrc_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [ipdrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipdrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ipdrc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_MUL_DEN   = 8'b0000_0010,
    ST_MUL_DIFF  = 8'b0000_0100,
    ST_SUM       = 8'b0000_1000,
    ST_MUL_DELAY = 8'b0001_0000,
    ST_DIV       = 8'b0010_0000,
    ST_CLAMP     = 8'b0100_0000,
    ST_FIN       = 8'b1000_0000
  } state_t;

  // Configuration registers.
  logic [RATE_W-1:0] thr_r;
  logic [FAC_W-1:0]  sn_r, sd_r, fn_r, fd_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [BLK_W-1:0]  total_r;

  // Sequencer and kept state.
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DELAY_W-1:0] cur_delay_r, cur_delay_nxt;
  logic [BLK_W-1:0]   cur_block_r, cur_block_nxt;

  // Working registers.
  logic                     gt_r, gt_nxt;
  logic [RATE_W-1:0]        span_r, span_nxt;
  logic [RATE_W-1:0]        rm_r, rm_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [DELAY_W-1:0]       res_delay_r, res_delay_nxt;
  logic [BLK_W-1:0]         res_block_r, res_block_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [DELAY_W-1:0]       out_delay_r, out_delay_nxt;
  logic [BLK_W-1:0]         out_block_r, out_block_nxt;

  // Decoded request and shared unit wiring.
  logic [RATE_W-1:0]          rate_sat;
  logic                       gt_in;
  logic [FAC_W-1:0]           sd_eff, fd_eff;
  logic                       blk_ok;
  logic signed [RATE_W-1:0]   fac_diff;
  logic signed [NUM_W-1:0]    num_sum;
  logic [CEIL_W-1:0]          ceil_v;
  logic [DELAY_W-1:0]         clamp_v;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic [DEN_W-1:0]           div_rem;
  logic                       div_qbit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      sn_r    <= FAC_W'(1);
      sd_r    <= FAC_W'(1);
      fn_r    <= FAC_W'(1);
      fd_r    <= FAC_W'(1);
      tgt_r   <= '0;
      total_r <= BLK_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:    thr_r   <= cfg_data[RATE_W-1:0];
        REG_SLOW_NUM:     sn_r    <= cfg_data[FAC_W-1:0];
        REG_SLOW_DEN:     sd_r    <= cfg_data[FAC_W-1:0];
        REG_FAST_NUM:     fn_r    <= cfg_data[FAC_W-1:0];
        REG_FAST_DEN:     fd_r    <= cfg_data[FAC_W-1:0];
        REG_TARGET:       tgt_r   <= cfg_data[TGT_W-1:0];
        REG_TOTAL_BLOCKS: total_r <= cfg_data[BLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request decoding: saturate and compare the rate, check the block, form factor terms.
  always_comb begin
    rate_sat = (in_ch.reported_error_rate > RATE_W'(RATE_SCALE)) ?
               RATE_W'(RATE_SCALE) : in_ch.reported_error_rate;
    gt_in    = (rate_sat > thr_r);
    sd_eff   = (sd_r == '0) ? FAC_W'(1) : sd_r;
    fd_eff   = (fd_r == '0) ? FAC_W'(1) : fd_r;
    blk_ok   = (in_ch.restart_block != '0) && (in_ch.restart_block <= total_r);
    fac_diff = $signed({1'b0, sn_r}) - $signed({1'b0, sd_eff});
    num_sum  = $signed(NUM_W'(den_r)) + NUM_W'(prod_r);
  end

  // Clamp the quotient to the ceiling, then raise it to the target.
  always_comb begin
    ceil_v  = (dvd_r > DVD_W'(DELAY_CEILING)) ? CEIL_W'(DELAY_CEILING) : dvd_r[CEIL_W-1:0];
    clamp_v = (DELAY_W'(ceil_v) < DELAY_W'(tgt_r)) ? DELAY_W'(tgt_r) : DELAY_W'(ceil_v);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_DEN: begin
        mul_a = $signed(MUL_A_W'(span_r));
        mul_b = $signed(MUL_B_W'(sd_eff));
      end
      ST_MUL_DIFF: begin
        mul_a = $signed(MUL_A_W'(rm_r));
        mul_b = MUL_B_W'(fac_diff);
      end
      ST_MUL_DELAY: begin
        if (gt_r) begin
          mul_a = num_r;
          mul_b = $signed(MUL_B_W'(cur_delay_r));
        end else begin
          mul_a = $signed(MUL_A_W'(cur_delay_r));
          mul_b = $signed(MUL_B_W'(fn_r));
        end
      end
      default: begin
      end
    endcase
  end

  ipdrc_unit u_unit (
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_p       (mul_p),
    .div_den     (den_r),
    .div_rem     (rem_r),
    .div_in_bit  (dvd_r[DVD_W-1]),
    .div_rem_nxt (div_rem),
    .div_qbit    (div_qbit)
  );

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    cur_delay_nxt  = cur_delay_r;
    cur_block_nxt  = cur_block_r;
    gt_nxt         = gt_r;
    span_nxt       = span_r;
    rm_nxt         = rm_r;
    den_nxt        = den_r;
    prod_nxt       = prod_r;
    num_nxt        = num_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_delay_nxt  = res_delay_r;
    res_block_nxt  = res_block_r;
    out_status_nxt = out_status_r;
    out_delay_nxt  = out_delay_r;
    out_block_nxt  = out_block_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_status_nxt = STAT_OK;
          res_delay_nxt  = cur_delay_r;
          res_block_nxt  = cur_block_r;
          gt_nxt         = gt_in;
          span_nxt       = RATE_W'(RATE_SCALE) - thr_r;
          rm_nxt         = rate_sat - thr_r + RATE_W'(1);
          den_nxt        = DEN_W'(fd_eff);
          unique case (in_ch.action)
            ACT_REPORT: begin
              state_nxt = gt_in ? ST_MUL_DEN : ST_MUL_DELAY;
            end
            ACT_RESTART: begin
              if (blk_ok) begin
                res_block_nxt = in_ch.restart_block;
              end else begin
                res_status_nxt = STAT_BAD_BLOCK;
              end
              state_nxt = ST_FIN;
            end
            ACT_START: begin
              res_delay_nxt = DELAY_W'(DELAY_W'(tgt_r) * DELAY_W'(3));
              res_block_nxt = '0;
              state_nxt     = ST_FIN;
            end
            default: begin
              res_status_nxt = STAT_UNKNOWN;
              state_nxt      = ST_FIN;
            end
          endcase
        end
      end
      ST_MUL_DEN: begin
        den_nxt   = mul_p[DEN_W-1:0];
        state_nxt = ST_MUL_DIFF;
      end
      ST_MUL_DIFF: begin
        prod_nxt  = mul_p[PROD_W-1:0];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // A factor at or below zero gives a zero delay before the clamp.
        if (num_sum[NUM_W-1] || (num_sum == '0)) begin
          dvd_nxt   = '0;
          state_nxt = ST_CLAMP;
        end else begin
          num_nxt   = num_sum;
          state_nxt = ST_MUL_DELAY;
        end
      end
      ST_MUL_DELAY: begin
        dvd_nxt   = mul_p[DVD_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DVD_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        dvd_nxt = {dvd_r[DVD_W-2:0], div_qbit};
        rem_nxt = div_rem;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        res_delay_nxt = clamp_v;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_status_nxt = res_status_r;
          out_delay_nxt  = res_delay_r;
          out_block_nxt  = res_block_r;
          cur_delay_nxt  = res_delay_r;
          cur_block_nxt  = res_block_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and kept delay and position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_delay_r <= '0;
      cur_block_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_delay_r <= cur_delay_nxt;
      cur_block_r <= cur_block_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    gt_r         <= gt_nxt;
    span_r       <= span_nxt;
    rm_r         <= rm_nxt;
    den_r        <= den_nxt;
    prod_r       <= prod_nxt;
    num_r        <= num_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_delay_r  <= res_delay_nxt;
    res_block_r  <= res_block_nxt;
    out_status_r <= out_status_nxt;
    out_delay_r  <= out_delay_nxt;
    out_block_r  <= out_block_nxt;
  end

  // Channel outputs.
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.delay_now      = out_delay_r;
  assign out_ch.block_position = out_block_r;

endmodule
